@@ rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked property that must also hold through reset.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

@@ rtl/bcc_pkg.sv @@
package bcc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int TIMER_W     = 12;
   localparam int DEBOUNCE_W  = 8;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSED_LEVELS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_DEBOUNCE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_DEBOUNCE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_CLICK = 3'd4;

   typedef enum logic [1:0] {
      ST_RELEASED   = 2'd0,
      ST_PRESS_DB   = 2'd1,
      ST_PRESSED    = 2'd2,
      ST_RELEASE_DB = 2'd3
   } stage_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_CLICK  = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   typedef struct packed {
      logic [1:0]            pressed_levels;
      logic [DEBOUNCE_W-1:0] press_debounce_ticks;
      logic [DEBOUNCE_W-1:0] release_debounce_ticks;
      logic [TIMER_W-1:0]    long_press_ticks;
      logic [TIMER_W-1:0]    double_click_ticks;
   } cfg_type;

   typedef struct packed {
      stage_type             stage;
      logic                  click_pending;
      logic                  long_flag;
      logic [1:0]            click_count;
      logic [TIMER_W-1:0]    window_timer;
      logic [TIMER_W-1:0]    press_timer;
      logic [DEBOUNCE_W-1:0] debounce_timer;
   } key_state_type;

   localparam key_state_type KEY_STATE_RESET = '{stage: ST_RELEASED, default: '0};

   function automatic logic [TIMER_W-1:0] sat_inc_timer(input logic [TIMER_W-1:0] v);
      return (v == {TIMER_W{1'b1}}) ? v : v + TIMER_W'(1);
   endfunction

   function automatic logic [DEBOUNCE_W-1:0] sat_inc_debounce(
      input logic [DEBOUNCE_W-1:0] v);
      return (v == {DEBOUNCE_W{1'b1}}) ? v : v + DEBOUNCE_W'(1);
   endfunction

endpackage

@@ rtl/bcc_if.sv @@
interface bcc_req_if;
   logic valid;
   logic ready;
   logic key_index;
   logic pin_level;

   modport source (output valid, key_index, pin_level, input ready);
   modport sink (input valid, key_index, pin_level, output ready);
endinterface

interface bcc_rsp_if;
   logic       valid;
   logic       ready;
   logic       key_id;
   logic [1:0] event_code;

   modport source (output valid, key_id, event_code, input ready);
   modport sink (input valid, key_id, event_code, output ready);
endinterface

interface bcc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [11:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/bcc_csr_regs.sv @@
module bcc_csr_regs import bcc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bcc_csr_if.sink   csr,
   output cfg_type   cfg
);

   cfg_type cfg_ff;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   // Writes to indexes past the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressed_levels         <= 2'd0;
         cfg_ff.press_debounce_ticks   <= DEBOUNCE_W'(1);
         cfg_ff.release_debounce_ticks <= DEBOUNCE_W'(1);
         cfg_ff.long_press_ticks       <= TIMER_W'(50);
         cfg_ff.double_click_ticks     <= TIMER_W'(15);
      end else if (csr.valid) begin
         case (csr.index)
            CSR_PRESSED_LEVELS:   cfg_ff.pressed_levels <= csr.data[1:0];
            CSR_PRESS_DEBOUNCE:   cfg_ff.press_debounce_ticks <= csr.data[DEBOUNCE_W-1:0];
            CSR_RELEASE_DEBOUNCE: cfg_ff.release_debounce_ticks <= csr.data[DEBOUNCE_W-1:0];
            CSR_LONG_PRESS:       cfg_ff.long_press_ticks <= csr.data[TIMER_W-1:0];
            CSR_DOUBLE_CLICK:     cfg_ff.double_click_ticks <= csr.data[TIMER_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

@@ rtl/bcc_key_step.sv @@
module bcc_key_step import bcc_pkg::*; (
   input  cfg_type       cfg,
   input  key_state_type cur_state,
   input  logic          key,
   input  logic          level,
   output key_state_type next_state,
   output event_type     event_out
);

   logic down;

   assign down = (level == cfg.pressed_levels[key]);

   always_comb begin
      next_state = cur_state;
      event_out  = EV_NONE;

      case (cur_state.stage)
         ST_RELEASED: begin
            if (down) begin
               next_state.stage          = ST_PRESS_DB;
               next_state.debounce_timer = '0;
               next_state.press_timer    = '0;
            end
         end
         ST_PRESS_DB: begin
            next_state.press_timer    = sat_inc_timer(cur_state.press_timer);
            next_state.debounce_timer = sat_inc_debounce(cur_state.debounce_timer);
            if (down) begin
               if (next_state.debounce_timer >= cfg.press_debounce_ticks) begin
                  next_state.stage = ST_PRESSED;
                  if (cur_state.click_count != 2'd3) begin
                     next_state.click_count = cur_state.click_count + 2'd1;
                  end
               end
            end else begin
               next_state.stage = ST_RELEASED;
            end
         end
         ST_PRESSED: begin
            next_state.press_timer = sat_inc_timer(cur_state.press_timer);
            if (!cur_state.long_flag && next_state.press_timer >= cfg.long_press_ticks) begin
               event_out            = EV_LONG;
               next_state.long_flag = 1'b1;
            end else if (!down) begin
               next_state.stage          = ST_RELEASE_DB;
               next_state.debounce_timer = '0;
            end
         end
         default: begin
            next_state.debounce_timer = sat_inc_debounce(cur_state.debounce_timer);
            if (!down && next_state.debounce_timer >= cfg.release_debounce_ticks) begin
               next_state.stage         = ST_RELEASED;
               next_state.click_pending = 1'b1;
            end
         end
      endcase

      // Click window: settle the click count once the window runs out or a
      // second press has been confirmed. A long press swallows the click or double click.
      if (next_state.click_pending) begin
         next_state.window_timer = sat_inc_timer(next_state.window_timer);
         if (next_state.window_timer >= cfg.double_click_ticks ||
             next_state.click_count >= 2'd2) begin
            if (!next_state.long_flag) begin
               if (next_state.click_count >= 2'd2) begin
                  event_out = EV_DOUBLE;
               end else if (next_state.click_count == 2'd1) begin
                  event_out = EV_CLICK;
               end
            end
            next_state.press_timer   = '0;
            next_state.click_count   = '0;
            next_state.window_timer  = '0;
            next_state.click_pending = 1'b0;
            next_state.long_flag     = 1'b0;
         end
      end
   end

endmodule

@@ rtl/button_click_classifier_unit.sv @@
// Button click classifier: debounce plus single-click, double-click and
// long-press detection for up to NUM_KEYS buttons.
// The req channel takes one word per periodic tick of one button, carrying
// the key index and the raw pin level. The rsp channel returns exactly one
// word per request word, in order, with the key id and an event code (none,
// single click, double click or long press).
// The csr channel writes the configuration registers by index; it is always
// ready and a write takes effect at the next clock edge. Registers should
// only be changed while no request is in flight.
// A request word waits in the input register until the response register
// is free or being drained, and then moves into the response register.
// Throughput is one word per cycle while the receiver takes every word;
// the per-key state is updated by the same edge that loads the response
// register, so a tick for the same key may follow directly.
// When the receiver stalls, the response register holds its word and the
// input register absorbs one more request before req.ready drops.
// Synchronous reset clears both pipeline valid flags, puts every key in the
// released stage with cleared timers, and restores the register defaults.
module button_click_classifier_unit import bcc_pkg::*; #(
   parameter int NUM_KEYS = 2
) (
   input logic      clock,
   input logic      reset,
   bcc_req_if.sink  req,
   bcc_rsp_if.source rsp,
   bcc_csr_if.sink  csr
);

   cfg_type       cfg;

   logic          in_valid_ff;
   logic          in_key_ff;
   logic          in_level_ff;

   logic          out_valid_ff;
   logic          out_valid_in;
   logic          out_key_ff;
   event_type     out_event_ff;

   key_state_type key_state_ff [NUM_KEYS];
   key_state_type cur_state;
   key_state_type key_state_in;
   event_type     step_event;
   event_type     out_event_in;

   logic          advance;
   logic          in_range;

   bcc_csr_regs u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   // The input word moves on whenever the response register is free or
   // being drained this cycle.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready    = !in_valid_ff || advance;
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   // A key index beyond the configured key count leaves all key state alone.
   assign in_range = (int'(in_key_ff) < NUM_KEYS);

   always_comb begin
      cur_state = KEY_STATE_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (int'(in_key_ff) == k) begin
            cur_state = key_state_ff[k];
         end
      end
   end

   bcc_key_step u_step (
      .cfg        (cfg),
      .cur_state  (cur_state),
      .key        (in_key_ff),
      .level      (in_level_ff),
      .next_state (key_state_in),
      .event_out  (step_event)
   );

   assign out_event_in = in_range ? step_event : EV_NONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            key_state_ff[k] <= KEY_STATE_RESET;
         end
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         out_valid_ff <= out_valid_in;
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (advance && in_range && int'(in_key_ff) == k) begin
               key_state_ff[k] <= key_state_in;
            end
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_key_ff   <= req.key_index;
         in_level_ff <= req.pin_level;
      end
      if (advance) begin
         out_key_ff   <= in_key_ff;
         out_event_ff <= out_event_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.key_id     = out_key_ff;
   assign rsp.event_code = out_event_ff;

endmodule

@@ rtl/bcc_checker.sv @@
`include "assert_macros.svh"

module bcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_key_id,
   input logic [1:0] rsp_event_code
);

   logic       req_take;
   logic       rsp_stall;
   logic [2:0] rsp_word;

   assign req_take  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_key_id, rsp_event_code};

   // No response word survives a reset.
   `ASSERT_CLK(a_reset_empties, clock, reset |=> !rsp_valid)

   // A stalled response word holds still.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_word))

   // Back-pressure on requests only comes from a full, stalled response stage.
   `ASSERT_CLK_RST(a_ready_cause, clock, reset, !req_ready |-> rsp_stall)

   // An accepted request moves from the input register into the response
   // register once that register is found empty.
   `ASSERT_CLK_RST(a_latency, clock, reset, req_take ##1 !rsp_valid |=> rsp_valid)

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_key_id     (rsp.key_id),
   .rsp_event_code (rsp.event_code)
);
